// ===== hdl/bitr_pkg.sv =====
// package for the beat interval tracker: types, codes and fixed widths
// used by the controller, the datapath and the top level
package bitr_pkg;

    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int STR_W      = 17;
    localparam int LIMIT_W    = 3;
    localparam int CONF_W     = 2;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 136;
    localparam int TUSER_W    = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [STR_W-1:0] STRENGTH_MAX = 17'd65536;

    localparam logic [MS_W-1:0]    MIN_INTERVAL_RST = 16'd300;
    localparam logic [MS_W-1:0]    MAX_INTERVAL_RST = 16'd1000;
    localparam logic [MS_W-1:0]    EVENT_WINDOW_RST = 16'd80;
    localparam logic [LIMIT_W-1:0] STABLE_LIMIT_RST = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_INTERVAL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EVENT_WINDOW = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STABLE_LIMIT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_UPDATE,
        ST_DIVIDE,
        ST_OUTPUT
    } bitr_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic update;
        logic div_step;
        logic out_load;
    } bitr_cmd_t;

    typedef struct packed {
        logic phase_valid;
    } bitr_stat_t;

endpackage

// ===== hdl/bitr_ctrl.sv =====
// controller for the beat interval tracker: request sequencing, divider
// step count and output valid; uses bitr_pkg
module bitr_ctrl #(
    parameter int PHASE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  bitr_pkg::bitr_stat_t stat,
    output bitr_pkg::bitr_cmd_t  cmd
);

    localparam int DIV_STEPS = 32 + PHASE_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    bitr_pkg::bitr_state_t state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bitr_pkg::ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            bitr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = bitr_pkg::ST_EVAL;
                end
            end
            bitr_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = bitr_pkg::ST_UPDATE;
            end
            bitr_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = stat.phase_valid ? bitr_pkg::ST_DIVIDE : bitr_pkg::ST_OUTPUT;
            end
            bitr_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = bitr_pkg::ST_OUTPUT;
                end
            end
            bitr_pkg::ST_OUTPUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bitr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bitr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hdl/bitr_dp.sv =====
// datapath for the beat interval tracker: config registers, event and lock
// state, interval checks, serial phase divider and output register; uses bitr_pkg
module bitr_dp #(
    parameter int TOLERANCE_DIVISOR = 4,
    parameter int PHASE_BITS        = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bitr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bitr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [bitr_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [bitr_pkg::TUSER_W-1:0]        s_tuser,
    input  bitr_pkg::bitr_cmd_t                 cmd,
    output bitr_pkg::bitr_stat_t                stat,
    output logic [bitr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [bitr_pkg::TUSER_W-1:0]        m_tuser
);

    localparam int TW    = bitr_pkg::TIME_W;
    localparam int MW    = bitr_pkg::MS_W;
    localparam int SW    = bitr_pkg::STR_W;
    localparam int LW    = bitr_pkg::LIMIT_W;
    localparam int DIVW  = TW + PHASE_BITS;
    localparam int PRODW = MW + 1 + 5;

    // config
    logic [MW-1:0] min_iv_reg, max_iv_reg, window_reg;
    logic [LW-1:0] limit_reg;

    // captured request
    logic [TW-1:0] now_reg;
    logic          silent_reg, onset_reg, bass_reg;
    logic [SW-1:0] on_s_reg, bass_s_reg;

    // tracker state
    logic [TW-1:0] last_reg, last_next;
    logic [MW-1:0] pe_reg, pe_next;
    logic [LW-1:0] sc_reg, sc_next;
    logic [TW-1:0] count_reg, count_next;
    logic [TW-1:0] etime_reg, etime_next;
    logic          hon_reg, hon_next, hbass_reg, hbass_next;
    logic [SW-1:0] hon_s_reg, hon_s_next, hbass_s_reg, hbass_s_next;
    logic          beat_reg, beat_next;

    // evaluation results
    logic [TW-1:0] age_e_reg, iv_e_reg;
    logic          active_e_reg, range_e_reg, near1_reg, near2_reg, near3_reg;

    // per-request results and divider
    logic [TW-1:0]                 age_out_reg, age_out_next;
    logic [bitr_pkg::CONF_W-1:0]   conf_reg, conf_next;
    logic                          valid_next;
    logic [TW-1:0]                 elapsed_next;
    logic [DIVW-1:0]               num_reg;
    logic [MW-1:0]                 rem_reg;
    logic [PHASE_BITS-1:0]         q_reg;
    logic [MW:0]                   rem_sh;
    logic                          rem_ge;
    logic [PHASE_BITS+MW-1:0]      q_ext;

    // output register
    logic [bitr_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [bitr_pkg::TUSER_W-1:0]   m_tuser_reg;

    logic [TW-1:0] age_c;
    logic [MW:0]   iv17, iv2, pe17, pe2;

    function automatic logic near_chk(input logic [MW:0] a, input logic [MW:0] b);
        logic [MW:0]    big;
        logic [MW:0]    sml;
        logic [PRODW-1:0] prod;
        big  = (a > b) ? a : b;
        sml  = (a > b) ? b : a;
        prod = PRODW'(big - sml) * PRODW'(TOLERANCE_DIVISOR);
        return (a != '0) && (b != '0) && (prod <= PRODW'(big));
    endfunction

    function automatic logic [SW-1:0] sat_str(input logic [SW-1:0] s);
        return (s > bitr_pkg::STRENGTH_MAX) ? bitr_pkg::STRENGTH_MAX : s;
    endfunction

    function automatic logic [MW-1:0] iv_e_next_lo(input logic [TW-1:0] n, input logic [TW-1:0] l);
        logic [TW-1:0] d;
        d = n - l;
        return d[MW-1:0];
    endfunction

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_iv_reg <= bitr_pkg::MIN_INTERVAL_RST;
            max_iv_reg <= bitr_pkg::MAX_INTERVAL_RST;
            window_reg <= bitr_pkg::EVENT_WINDOW_RST;
            limit_reg  <= bitr_pkg::STABLE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bitr_pkg::REG_MIN_INTERVAL: min_iv_reg <= cfg_wdata[MW-1:0];
                bitr_pkg::REG_MAX_INTERVAL: max_iv_reg <= cfg_wdata[MW-1:0];
                bitr_pkg::REG_EVENT_WINDOW: window_reg <= cfg_wdata[MW-1:0];
                bitr_pkg::REG_STABLE_LIMIT: limit_reg  <= cfg_wdata[LW-1:0];
                default:                    limit_reg  <= limit_reg;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg    <= s_tdata[TW-1:0];
            on_s_reg   <= s_tdata[TW+SW-1:TW];
            bass_s_reg <= s_tdata[TW+2*SW-1:TW+SW];
            silent_reg <= s_tuser[0];
            onset_reg  <= s_tuser[1];
            bass_reg   <= s_tuser[2];
        end
    end

    // age, interval and closeness checks
    assign age_c = ((etime_reg == '0) || (now_reg < etime_reg)) ? '1 : now_reg - etime_reg;
    assign iv17  = {1'b0, iv_e_next_lo(now_reg, last_reg)};
    assign iv2   = {iv17[MW-1:0], 1'b0};
    assign pe17  = {1'b0, pe_reg};
    assign pe2   = {pe_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            age_e_reg    <= age_c;
            active_e_reg <= (age_c <= TW'(window_reg));
            iv_e_reg     <= (last_reg == '0) ? '0 : now_reg - last_reg;
            range_e_reg  <= ((now_reg - last_reg) >= TW'(min_iv_reg))
                         && ((now_reg - last_reg) <= TW'(max_iv_reg));
            near1_reg    <= near_chk(iv17, pe17);
            near2_reg    <= near_chk(iv2, pe17);
            near3_reg    <= near_chk(iv17, pe2);
        end
    end

    // state update
    always_comb
    begin
        logic          accepted;
        logic [MW+1:0] blend;
        last_next    = last_reg;
        pe_next      = pe_reg;
        sc_next      = sc_reg;
        count_next   = count_reg;
        etime_next   = etime_reg;
        hon_next     = active_e_reg & hon_reg;
        hbass_next   = active_e_reg & hbass_reg;
        hon_s_next   = active_e_reg ? hon_s_reg : '0;
        hbass_s_next = active_e_reg ? hbass_s_reg : '0;
        beat_next    = active_e_reg & beat_reg;
        age_out_next = age_e_reg;
        conf_next    = '0;
        valid_next   = 1'b0;
        accepted     = onset_reg | bass_reg;
        blend        = (MW+2)'(pe_reg) * (MW+2)'(3) + (MW+2)'(iv_e_reg[MW-1:0]);
        if (silent_reg)
        begin
            last_next    = '0;
            pe_next      = (sc_reg <= LW'(1)) ? '0 : pe_reg;
            sc_next      = '0;
            hon_next     = 1'b0;
            hbass_next   = 1'b0;
            hon_s_next   = '0;
            hbass_s_next = '0;
            beat_next    = 1'b0;
        end
        else
        begin
            if (accepted)
            begin
                if (iv_e_reg != '0)
                begin
                    if (!range_e_reg)
                    begin
                        pe_next = (sc_reg <= LW'(1)) ? '0 : pe_reg;
                        sc_next = '0;
                    end
                    else if (pe_reg == '0)
                    begin
                        pe_next = iv_e_reg[MW-1:0];
                    end
                    else if (near1_reg && !near2_reg && !near3_reg)
                    begin
                        pe_next = blend[MW+1:2];
                        if (sc_reg < limit_reg)
                        begin
                            sc_next = sc_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pe_next = iv_e_reg[MW-1:0];
                        sc_next = '0;
                    end
                end
                last_next    = now_reg;
                count_next   = count_reg + 1'b1;
                etime_next   = now_reg;
                age_out_next = '0;
                hon_next     = onset_reg;
                hbass_next   = bass_reg;
                hon_s_next   = onset_reg ? sat_str(on_s_reg) : '0;
                hbass_s_next = bass_reg ? sat_str(bass_s_reg) : '0;
            end
            valid_next = (pe_next >= min_iv_reg) && (pe_next != '0) && (last_next != '0);
            if (valid_next)
            begin
                conf_next = (sc_next > LW'(2)) ? 2'd2 : sc_next[1:0];
                if (accepted && (sc_next != '0))
                begin
                    beat_next = 1'b1;
                end
            end
        end
        elapsed_next = now_reg - last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= '0;
            pe_reg      <= '0;
            sc_reg      <= '0;
            count_reg   <= '0;
            etime_reg   <= '0;
            hon_reg     <= 1'b0;
            hbass_reg   <= 1'b0;
            hon_s_reg   <= '0;
            hbass_s_reg <= '0;
            beat_reg    <= 1'b0;
        end
        else if (cmd.update)
        begin
            last_reg    <= last_next;
            pe_reg      <= pe_next;
            sc_reg      <= sc_next;
            count_reg   <= count_next;
            etime_reg   <= etime_next;
            hon_reg     <= hon_next;
            hbass_reg   <= hbass_next;
            hon_s_reg   <= hon_s_next;
            hbass_s_reg <= hbass_s_next;
            beat_reg    <= beat_next;
        end
    end

    // phase divider: restoring division of {elapsed, zeros} by the estimate
    assign rem_sh = {rem_reg, num_reg[DIVW-1]};
    assign rem_ge = (rem_sh >= {1'b0, pe_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            age_out_reg <= age_out_next;
            conf_reg    <= conf_next;
            num_reg     <= {elapsed_next, {PHASE_BITS{1'b0}}};
            rem_reg     <= '0;
            q_reg       <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[DIVW-2:0], 1'b0};
            rem_reg <= rem_ge ? MW'(rem_sh - {1'b0, pe_reg}) : rem_sh[MW-1:0];
            q_reg   <= {q_reg[PHASE_BITS-2:0], rem_ge};
        end
    end

    assign stat.phase_valid = valid_next;
    assign q_ext = {{MW{1'b0}}, q_reg};

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {4'b0, pe_reg, conf_reg, q_ext[MW-1:0], hbass_s_reg, hon_s_reg,
                            age_out_reg, count_reg};
            m_tuser_reg <= {beat_reg, hbass_reg, hon_reg};
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ===== hdl/beat_interval_tracker_top.sv =====
// beat interval tracker, one request in and one request out at a time;
// an accepted request passes capture, evaluation and state update, then the
// one-bit-per-cycle restoring phase divider when a phase is computed, then
// loads the output register once that is free; no new request is taken before
// that load, and the output register frees the input side
// rst_n clears config to defaults and all tracker state to zero at once
module beat_interval_tracker_top #(
    parameter int TOLERANCE_DIVISOR = 4,
    parameter int PHASE_BITS        = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame_time_ms[31:0], onset_level[48:32], kick_level[65:49], zero fill
    input  logic [bitr_pkg::S_TDATA_W-1:0]  s_tdata,
    // silent[0], onset[1], kick_onset[2]
    input  logic [bitr_pkg::TUSER_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // event_count[31:0], event_age[63:32], onset_level_held[80:64],
    // kick_level_held[97:81], pulse_phase[113:98], pulse_conf[115:114],
    // period_estimate_ms[131:116], zero fill
    output logic [bitr_pkg::M_TDATA_W-1:0]  m_tdata,
    // onset_held[0], bass_held[1], beat[2]
    output logic [bitr_pkg::TUSER_W-1:0]    m_tuser,
    input  logic                            cfg_we,
    input  logic [bitr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bitr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    bitr_pkg::bitr_cmd_t  cmd;
    bitr_pkg::bitr_stat_t stat;

    bitr_ctrl #(
        .PHASE_BITS (PHASE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bitr_dp #(
        .TOLERANCE_DIVISOR (TOLERANCE_DIVISOR),
        .PHASE_BITS        (PHASE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== hdl/bitr_checker.sv =====
// port-level checks for the beat interval tracker and the bind that
// attaches them to beat_interval_tracker_top; uses bitr_pkg
module bitr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [bitr_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [bitr_pkg::TUSER_W-1:0]    s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bitr_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [bitr_pkg::TUSER_W-1:0]    m_tuser,
    input logic                            cfg_we,
    input logic [bitr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input logic [bitr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // no confidence without an estimate
    a_conf_needs_period: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[131:116] == 16'd0) |-> (m_tdata[115:114] == 2'd0))
        else $error("confidence with empty period estimate");

    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[115:114] != 2'd3))
        else $error("confidence out of range");

    // held strength implies held flag
    a_strength_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[80:64] != 17'd0) |-> m_tuser[0])
        else $error("onset strength held without onset flag");

endmodule

bind beat_interval_tracker_top bitr_checker u_bitr_checker (.*);
